// File: hw/rtl/lcnc_pkg.sv
// ============================================================================
// lcnc_pkg - shared types and constants for the card number classifier
// Widths of the binary and BCD datapaths, sequencer states, class codes and
// the control/status bundles passed between the sequencer and its units.
// ============================================================================
package lcnc_pkg;

  localparam int PAN_W       = 54;
  // A 54-bit value holds at most 17 decimal digits
  localparam int BCD_DIGITS  = 17;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  // Binary bits shifted into the BCD register per conversion cycle
  localparam int STEP_BITS   = 3;
  localparam int CONV_STEPS  = PAN_W / STEP_BITS;
  localparam int STEP_CNT_W  = $clog2(CONV_STEPS);
  localparam int CNT_W       = 5;
  localparam int MAX_DIGITS  = 16;

  localparam logic [1:0] CLASS_INVALID = 2'd0;
  localparam logic [1:0] CLASS_LEAD4   = 2'd1;
  localparam logic [1:0] CLASS_LEAD5X  = 2'd2;
  localparam logic [1:0] CLASS_LEAD3X  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LOADW,
    ST_WALK,
    ST_DONE
  } lcnc_state_t;

  typedef struct packed {
    logic load;
    logic run;
  } lcnc_ctrl_t;

  typedef struct packed {
    logic             rest_zero;
    logic [CNT_W-1:0] count;
    logic [3:0]       sum_mod;
    logic [3:0]       lead1;
    logic [3:0]       lead2;
  } lcnc_walk_t;

endpackage

// File: hw/rtl/lcnc_bcd_conv.sv
// ============================================================================
// lcnc_bcd_conv - iterative binary to BCD converter
// Shift-and-add-3 unit that moves a few binary bits into the BCD register
// each cycle it is told to run.
// ============================================================================
module lcnc_bcd_conv (
  input  logic                         clk,
  input  lcnc_pkg::lcnc_ctrl_t         ctrl,
  input  logic [lcnc_pkg::PAN_W-1:0]   pan_value,
  output logic [lcnc_pkg::BCD_W-1:0]   bcd
);

  logic [lcnc_pkg::PAN_W-1:0] bin;
  logic [lcnc_pkg::BCD_W-1:0] bcd_next;

  // Adjust each digit, then shift one binary bit in, STEP_BITS times
  always_comb begin
    bcd_next = bcd;
    for (int s = 0; s < lcnc_pkg::STEP_BITS; s++) begin
      for (int n = 0; n < lcnc_pkg::BCD_DIGITS; n++) begin
        if (bcd_next[4*n +: 4] >= 4'd5) begin
          bcd_next[4*n +: 4] = bcd_next[4*n +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[lcnc_pkg::BCD_W-2:0], bin[lcnc_pkg::PAN_W-1-s]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= pan_value;
      bcd <= '0;
    end else if (ctrl.run) begin
      bin <= {bin[lcnc_pkg::PAN_W-lcnc_pkg::STEP_BITS-1:0], {lcnc_pkg::STEP_BITS{1'b0}}};
      bcd <= bcd_next;
    end
  end

endmodule

// File: hw/rtl/lcnc_luhn_acc.sv
// ============================================================================
// lcnc_luhn_acc - digit walker and Luhn accumulator
// Walks the BCD digits from the low end, one per cycle while run is high,
// keeping the digit count, the Luhn sum modulo ten and the two top digits.
// ============================================================================
module lcnc_luhn_acc (
  input  logic                        clk,
  input  lcnc_pkg::lcnc_ctrl_t        ctrl,
  input  logic [lcnc_pkg::BCD_W-1:0]  bcd,
  output lcnc_pkg::lcnc_walk_t        status
);

  logic [lcnc_pkg::BCD_W-1:0] rest;
  logic [lcnc_pkg::CNT_W-1:0] count;
  logic [3:0]                 sum_mod;
  logic [3:0]                 lead1;
  logic [3:0]                 lead2;

  logic [3:0] digit;
  logic [4:0] dbl_raw;
  logic [3:0] term;
  logic [4:0] sum_raw;
  logic [3:0] sum_next;

  assign digit   = rest[3:0];
  assign dbl_raw = {digit, 1'b0};

  always_comb begin
    // Odd positions are doubled, folding 10..18 back to 1..9
    if (count[0]) begin
      if (dbl_raw > 5'd9) begin
        term = 4'(dbl_raw - 5'd9);
      end else begin
        term = dbl_raw[3:0];
      end
    end else begin
      term = digit;
    end
    sum_raw = {1'b0, sum_mod} + {1'b0, term};
    if (sum_raw >= 5'd10) begin
      sum_next = 4'(sum_raw - 5'd10);
    end else begin
      sum_next = sum_raw[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rest    <= bcd;
      count   <= '0;
      sum_mod <= '0;
      lead1   <= '0;
      lead2   <= '0;
    end else if (ctrl.run) begin
      rest    <= {4'd0, rest[lcnc_pkg::BCD_W-1:4]};
      count   <= count + 1'b1;
      sum_mod <= sum_next;
      lead2   <= lead1;
      lead1   <= digit;
    end
  end

  assign status.rest_zero = (rest == '0);
  assign status.count     = count;
  assign status.sum_mod   = sum_mod;
  assign status.lead1     = lead1;
  assign status.lead2     = lead2;

endmodule

// File: hw/rtl/luhn_card_number_classifier.sv
// ============================================================================
// luhn_card_number_classifier - Luhn mod-10 check and card number class
// Converts a binary card number to decimal digits, checks the Luhn sum,
// counts the digits and classifies the number by length and leading digits.
// ============================================================================
//
// Usage:
//   Input channel: drive pan_value and raise start. A transaction is taken
//   at a rising edge with start high and busy low. busy stays high from the
//   next cycle until the result has been shown.
//   Result channel: done is high for exactly one cycle with card_class,
//   luhn_ok and digit_count valid in that cycle. The receiver cannot stall;
//   the result is flagged by done only in that cycle.
//   Sequence: the shift-and-add-3 converter shifts 3 bits in per step until
//   the whole value is converted, the digit walker is then loaded, the
//   walker takes one digit per cycle until the number is exhausted, and
//   the result cycle follows with done high. The next transaction can be
//   taken once the block is back in idle after done. The converter loop
//   and the one-digit-per-cycle walker set the time one number takes.
//   Reset: rst (synchronous, active high) returns the sequencer to idle and
//   drops any transaction in flight; no result is produced for it.
//
module luhn_card_number_classifier #(
  parameter int MAX_DIGITS = lcnc_pkg::MAX_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lcnc_pkg::PAN_W-1:0]  pan_value,
  output logic                        busy,
  output logic                        done,
  output logic [1:0]                  card_class,
  output logic                        luhn_ok,
  output logic [4:0]                  digit_count
);

  lcnc_pkg::lcnc_state_t state, state_next;
  logic [lcnc_pkg::STEP_CNT_W-1:0] step_cnt;
  logic                            conv_last;

  lcnc_pkg::lcnc_ctrl_t conv_ctrl;
  lcnc_pkg::lcnc_ctrl_t walk_ctrl;
  lcnc_pkg::lcnc_walk_t walk_status;
  logic [lcnc_pkg::BCD_W-1:0] bcd;

  assign conv_last = (step_cnt == lcnc_pkg::STEP_CNT_W'(lcnc_pkg::CONV_STEPS - 1));

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      lcnc_pkg::ST_IDLE: begin
        if (start) state_next = lcnc_pkg::ST_CONV;
      end
      lcnc_pkg::ST_CONV: begin
        if (conv_last) state_next = lcnc_pkg::ST_LOADW;
      end
      lcnc_pkg::ST_LOADW: begin
        state_next = lcnc_pkg::ST_WALK;
      end
      lcnc_pkg::ST_WALK: begin
        if (walk_status.rest_zero) state_next = lcnc_pkg::ST_DONE;
      end
      lcnc_pkg::ST_DONE: begin
        state_next = lcnc_pkg::ST_IDLE;
      end
      default: state_next = lcnc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lcnc_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      // Advance the conversion step counter only while converting
      if (state == lcnc_pkg::ST_CONV) begin
        step_cnt <= conv_last ? '0 : step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
    end
  end

  // Output / control decode
  always_comb begin
    busy           = 1'b1;
    done           = 1'b0;
    conv_ctrl.load = 1'b0;
    conv_ctrl.run  = 1'b0;
    walk_ctrl.load = 1'b0;
    walk_ctrl.run  = 1'b0;
    unique case (state)
      lcnc_pkg::ST_IDLE: begin
        busy           = 1'b0;
        conv_ctrl.load = start;
      end
      lcnc_pkg::ST_CONV: begin
        conv_ctrl.run = 1'b1;
      end
      lcnc_pkg::ST_LOADW: begin
        walk_ctrl.load = 1'b1;
      end
      lcnc_pkg::ST_WALK: begin
        // Consume one digit per cycle until nothing nonzero remains
        walk_ctrl.run = !walk_status.rest_zero;
      end
      lcnc_pkg::ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  lcnc_bcd_conv u_conv (
    .clk       (clk),
    .ctrl      (conv_ctrl),
    .pan_value (pan_value),
    .bcd       (bcd)
  );

  lcnc_luhn_acc u_walk (
    .clk    (clk),
    .ctrl   (walk_ctrl),
    .bcd    (bcd),
    .status (walk_status)
  );

  // Classification from the walker's final state; lead1 is the top digit
  always_comb begin
    luhn_ok     = (walk_status.sum_mod == 4'd0);
    digit_count = walk_status.count;
    card_class  = lcnc_pkg::CLASS_INVALID;
    if (luhn_ok && (walk_status.count <= lcnc_pkg::CNT_W'(MAX_DIGITS))) begin
      if ((walk_status.count == 5'd13 || walk_status.count == 5'd16) &&
          walk_status.lead1 == 4'd4) begin
        card_class = lcnc_pkg::CLASS_LEAD4;
      end else if (walk_status.count == 5'd16 && walk_status.lead1 == 4'd5 &&
                   walk_status.lead2 >= 4'd1 && walk_status.lead2 <= 4'd5) begin
        card_class = lcnc_pkg::CLASS_LEAD5X;
      end else if (walk_status.count == 5'd15 && walk_status.lead1 == 4'd3 &&
                   (walk_status.lead2 == 4'd4 || walk_status.lead2 == 4'd7)) begin
        card_class = lcnc_pkg::CLASS_LEAD3X;
      end
    end
  end

  // A taken transaction makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  // The result strobe lasts one cycle and is followed by idle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("done not a single-cycle strobe followed by idle");

  // No class is reported for a number failing the Luhn check
  a_class_needs_luhn: assert property (@(posedge clk) disable iff (rst)
    (done && !luhn_ok) |-> (card_class == lcnc_pkg::CLASS_INVALID))
    else $error("class reported with failing Luhn sum");

  // The walker can never count more digits than the BCD register holds
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (digit_count <= 5'd17))
    else $error("digit count out of range");

endmodule
